// File: design/pitot_airspeed_calc_core_assert.svh
// Assertion macros for the pitot airspeed core checker.
// Depends on nothing; included by the checker file only.
`ifndef PITOT_AIRSPEED_CALC_CORE_ASSERT_SVH
`define PITOT_AIRSPEED_CALC_CORE_ASSERT_SVH

// Generic form with an explicit clock and active-low reset.
`define PAC_CHECK_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pitot airspeed check failed");

// Short form on the core clock and reset.
`define PAC_CHECK(lbl, prop) `PAC_CHECK_CLK(lbl, aclk, aresetn, prop)

`endif

// File: design/pac_pkg.sv
// Shared types and constants of the pitot airspeed core.
// Depends on nothing; used by the core.
package pac_pkg;

    localparam logic [1:0]  CFG_GAS_CONSTANT  = 2'd0;
    localparam logic [1:0]  CFG_SEA_DENSITY   = 2'd1;

    localparam logic [19:0] GAS_RESET         = 20'd287050;
    localparam logic [15:0] DENSITY_RESET     = 16'd12250;

    // 2 * 10^8: factor two of the dynamic pressure and the density scale.
    localparam logic [27:0] IAS_SCALE         = 28'd200000000;
    localparam logic [15:0] KELVIN_OFFSET     = 16'd27315;
    localparam logic [15:0] SPEED_MAX         = 16'hFFFF;

    typedef struct packed {
        logic neg;
        logic zs;
        logic ias_sat;
    } flags_t;

endpackage

// File: design/pac_div.sv
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
// Depends on nothing; the caller guarantees the quotient fits in 32 bits.
module pac_div #(
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [31:0]   in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [31:0]   out_quo,
    output logic [SW-1:0] out_side
);

    logic          valid_reg [0:31];
    logic [DW-1:0] rem_reg   [0:31];
    logic [31:0]   num_reg   [0:31];
    logic [DW-1:0] den_reg   [0:31];
    logic [SW-1:0] side_reg  [0:31];

    logic          src_valid [0:31];
    logic [DW-1:0] src_rem   [0:31];
    logic [31:0]   src_num   [0:31];
    logic [DW-1:0] src_den   [0:31];
    logic [SW-1:0] src_side  [0:31];

    always_comb begin
        src_valid[0] = in_valid;
        src_rem[0]   = in_rem;
        src_num[0]   = in_num;
        src_den[0]   = in_den;
        src_side[0]  = in_side;
        for (int i = 1; i < 32; i++) begin
            src_valid[i] = valid_reg[i-1];
            src_rem[i]   = rem_reg[i-1];
            src_num[i]   = num_reg[i-1];
            src_den[i]   = den_reg[i-1];
            src_side[i]  = side_reg[i-1];
        end
    end

    for (genvar g = 0; g < 32; g++) begin : g_stage
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        // The numerator word shifts left and the quotient bit enters at the bottom.
        assign trial = {src_rem[g], src_num[g][31]};
        assign ge    = trial >= {1'b0, src_den[g]};
        assign diff  = trial - {1'b0, src_den[g]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (en) begin
                valid_reg[g] <= src_valid[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                num_reg[g]  <= {src_num[g][30:0], ge};
                den_reg[g]  <= src_den[g];
                side_reg[g] <= src_side[g];
            end
        end
    end

    assign out_valid = valid_reg[31];
    assign out_quo   = num_reg[31];
    assign out_side  = side_reg[31];

endmodule

// File: design/pac_sqrt.sv
// Pipelined integer square root of a 32-bit word, one root bit per stage.
// Depends on nothing; gives the root rounded down in 16 stages.
module pac_sqrt #(
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [31:0]   in_rad,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [15:0]   out_root,
    output logic [SW-1:0] out_side
);

    logic          valid_reg [0:15];
    logic [17:0]   rem_reg   [0:15];
    logic [15:0]   root_reg  [0:15];
    logic [31:0]   rad_reg   [0:15];
    logic [SW-1:0] side_reg  [0:15];

    logic          src_valid [0:15];
    logic [17:0]   src_rem   [0:15];
    logic [15:0]   src_root  [0:15];
    logic [31:0]   src_rad   [0:15];
    logic [SW-1:0] src_side  [0:15];

    always_comb begin
        src_valid[0] = in_valid;
        src_rem[0]   = 18'd0;
        src_root[0]  = 16'd0;
        src_rad[0]   = in_rad;
        src_side[0]  = in_side;
        for (int i = 1; i < 16; i++) begin
            src_valid[i] = valid_reg[i-1];
            src_rem[i]   = rem_reg[i-1];
            src_root[i]  = root_reg[i-1];
            src_rad[i]   = rad_reg[i-1];
            src_side[i]  = side_reg[i-1];
        end
    end

    for (genvar g = 0; g < 16; g++) begin : g_stage
        logic [19:0] part;
        logic [19:0] trial;
        logic [19:0] diff;
        logic        ge;

        // Bring down two radicand bits and try the next root bit as one.
        assign part  = {src_rem[g], src_rad[g][31:30]};
        assign trial = {2'b00, src_root[g], 2'b01};
        assign ge    = part >= trial;
        assign diff  = part - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (en) begin
                valid_reg[g] <= src_valid[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= ge ? diff[17:0] : part[17:0];
                root_reg[g] <= {src_root[g][14:0], ge};
                rad_reg[g]  <= {src_rad[g][29:0], 2'b00};
                side_reg[g] <= src_side[g];
            end
        end
    end

    assign out_valid = valid_reg[15];
    assign out_root  = root_reg[15];
    assign out_side  = side_reg[15];

endmodule

// File: design/pitot_airspeed_calc_core.sv
// Pipeline from input request to result: 3 arithmetic stages,
// 32 divider stages, 16 square root stages, 1 output register.
// Throughput: one request per cycle; a stalled output holds the whole pipeline.
// Reset (aresetn low, synchronous) empties the pipeline and restores both
// configuration registers to their defaults.
module pitot_airspeed_calc_core
    import pac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [16:0] pitot_pressure, [33:17] static_pressure_in, [48:34] air_temp_centi
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] indicated_speed, [31:16] true_speed
    output logic [31:0] m_tdata,
    // [0] negative_difference, [1] zero_static, [2] speed_saturated
    output logic [2:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic        en;
    logic [19:0] gas_reg;
    logic [15:0] dens_reg;

    logic [16:0] in_pt;
    logic [16:0] in_ps;
    logic [14:0] in_temp;

    logic        v1_reg, v2_reg, v3_reg;
    logic [16:0] dp1_reg, dp2_reg;
    logic [15:0] tk1_reg;
    logic [20:0] den1_reg, den2_reg, den3_reg;
    logic [15:0] dn1_reg, dn2_reg, dn3_reg;
    logic        neg1_reg, neg2_reg, neg3_reg;
    logic        zs1_reg, zs2_reg, zs3_reg;
    logic [44:0] ias2_reg, ias3_reg;
    logic [32:0] p2_reg;
    logic [53:0] tas3_reg;

    logic [16:0] dp_next;
    logic [52:0] tas_prod;
    logic        ias_sat;
    logic        tas_sat;
    flags_t      flags_in;

    logic        dva, dvb, sva, svb;
    logic [31:0] qa, qb;
    flags_t      fa, fs;
    logic        ta, ts;
    logic [15:0] ra, rb;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    assign in_pt   = s_tdata[16:0];
    assign in_ps   = s_tdata[33:17];
    assign in_temp = s_tdata[48:34];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gas_reg  <= GAS_RESET;
            dens_reg <= DENSITY_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GAS_CONSTANT: gas_reg  <= cfg_data;
                CFG_SEA_DENSITY:  dens_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign dp_next = in_pt - in_ps;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign tas_prod = {20'd0, p2_reg} * {33'd0, gas_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            // Stage 1: difference, absolute temperature, divisors.
            neg1_reg <= in_pt < in_ps;
            zs1_reg  <= in_ps == 17'd0;
            dp1_reg  <= (in_pt < in_ps) ? 17'd0 : dp_next;
            tk1_reg  <= {in_temp[14], in_temp} + KELVIN_OFFSET;
            den1_reg <= {1'b0, in_ps, 3'b000} + {3'b000, in_ps, 1'b0};
            dn1_reg  <= (dens_reg == 16'd0) ? 16'd1 : dens_reg;
            // Stage 2: first products.
            ias2_reg <= {28'd0, dp1_reg} * {17'd0, IAS_SCALE};
            p2_reg   <= {16'd0, dp1_reg} * {17'd0, tk1_reg};
            den2_reg <= den1_reg;
            dn2_reg  <= dn1_reg;
            neg2_reg <= neg1_reg;
            zs2_reg  <= zs1_reg;
            // Stage 3: gas constant product, doubled.
            tas3_reg <= {tas_prod, 1'b0};
            ias3_reg <= ias2_reg;
            den3_reg <= den2_reg;
            dn3_reg  <= dn2_reg;
            neg3_reg <= neg2_reg;
            zs3_reg  <= zs2_reg;
        end
    end

    // A quotient of 2^32 or more means a root above the speed range.
    assign ias_sat = {3'b000, ias3_reg[44:32]} >= dn3_reg;
    assign tas_sat = tas3_reg[53:32] >= {1'b0, den3_reg};

    assign flags_in = '{neg: neg3_reg, zs: zs3_reg, ias_sat: ias_sat};

    pac_div #(.DW(16), .SW($bits(flags_t))) u_div_ias (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rem    ({3'b000, ias3_reg[44:32]}),
        .in_num    (ias3_reg[31:0]),
        .in_den    (dn3_reg),
        .in_side   (flags_in),
        .out_valid (dva),
        .out_quo   (qa),
        .out_side  (fa)
    );

    pac_div #(.DW(21), .SW(1)) u_div_tas (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rem    (tas3_reg[52:32]),
        .in_num    (tas3_reg[31:0]),
        .in_den    (den3_reg),
        .in_side   (tas_sat),
        .out_valid (dvb),
        .out_quo   (qb),
        .out_side  (ta)
    );

    pac_sqrt #(.SW($bits(flags_t))) u_sqrt_ias (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dva && dvb),
        .in_rad    (qa),
        .in_side   (fa),
        .out_valid (sva),
        .out_root  (ra),
        .out_side  (fs)
    );

    pac_sqrt #(.SW(1)) u_sqrt_tas (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dva && dvb),
        .in_rad    (qb),
        .in_side   (ta),
        .out_valid (svb),
        .out_root  (rb),
        .out_side  (ts)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= sva && svb;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg[15:0]  <= fs.neg ? 16'd0 : (fs.ias_sat ? SPEED_MAX : ra);
            m_tdata_reg[31:16] <= (fs.neg || fs.zs) ? 16'd0 : (ts ? SPEED_MAX : rb);
            m_tuser_reg[0]     <= fs.neg;
            m_tuser_reg[1]     <= fs.zs;
            m_tuser_reg[2]     <= !fs.neg && (fs.ias_sat || (ts && !fs.zs));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: design/pac_checker.sv
// Port-level checks on the pitot airspeed core, bound to its top level.
// Depends on pitot_airspeed_calc_core_assert.svh for the assertion macros.
`include "pitot_airspeed_calc_core_assert.svh"

module pac_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A negative difference forces both speeds to zero and never saturates.
    `PAC_CHECK(a_neg_zero, m_tvalid && m_tuser[0] |-> m_tdata == 32'd0 && !m_tuser[2])

    // Zero static pressure leaves no true speed.
    `PAC_CHECK(a_zs_zero, m_tvalid && m_tuser[1] |-> m_tdata[31:16] == 16'd0)

    // The saturation flag implies at least one speed at its ceiling.
    `PAC_CHECK(a_sat_max, m_tvalid && m_tuser[2] |-> m_tdata[15:0] == 16'hFFFF || m_tdata[31:16] == 16'hFFFF)

    // A result that is not taken stays unchanged.
    `PAC_CHECK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind pitot_airspeed_calc_core pac_checker u_pac_checker (.*);
